### hw/rtl/mre_pkg.sv
// ----------------------------------------------------------------------------
// mre_pkg
// Shared widths, limits, word and status types for the reconstruction
// error meter.
// ----------------------------------------------------------------------------
`default_nettype none

package mre_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int CSUM_W         = 23;
  localparam int ERR_W          = 22;
  localparam int SQ_W           = 2 * ERR_W;
  localparam int SUM_W          = 64;
  localparam int COUNT_W        = 32;
  localparam int RMS_W          = 30;

  localparam int MAX_COMPONENTS = 65;
  localparam int FRAC_BITS      = 8;
  localparam int CSUM_BOUND     = MAX_COMPONENTS * 32768;

  // long division of (sum << 2F) by the count, one quotient bit a step
  localparam int NUM_W          = SUM_W + 2 * FRAC_BITS;
  localparam int QUO_W          = 62;
  localparam int DIV_STEPS      = NUM_W;
  localparam int SQRT_STEPS     = QUO_W / 2;
  localparam int STEP_W         = $clog2(DIV_STEPS);

  // depth must be a power of two: pointers wrap naturally
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RMS_W-1:0] RMS_MAX  = {RMS_W{1'b1}};
  localparam logic [QUO_W-1:0] ONE_INIT = QUO_W'(1) << (QUO_W - 2);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // one word per closed position or signal end
  typedef struct packed {
    logic             close;
    logic             last;
    logic [ERR_W-1:0] abs_err;
  } mre_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mre_q_status_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_PREP,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

### hw/rtl/mre_if.sv
// ----------------------------------------------------------------------------
// mre_if
// Valid/ready channels: sample words in, result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mre_in_if import mre_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_value;
  logic    is_component;
  logic    position_last;
  logic    signal_last;

  modport source (output valid, sample_value, is_component, position_last, signal_last,
                  input ready);
  modport sink   (input valid, sample_value, is_component, position_last, signal_last,
                  output ready);
endinterface

interface mre_out_if import mre_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ERR_W-1:0]   peak_abs_error;
  logic [RMS_W-1:0]   rms_error_q8;
  logic [COUNT_W-1:0] positions_seen;
  logic               sum_saturated;

  modport source (output valid, peak_abs_error, rms_error_q8, positions_seen, sum_saturated,
                  input ready);
  modport sink   (input valid, peak_abs_error, rms_error_q8, positions_seen, sum_saturated,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/mre_front.sv
// ----------------------------------------------------------------------------
// mre_front
// Takes sample words, holds the mixture and the saturating component sum
// of the open position, and queues the absolute error when a position
// closes or the signal ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_front import mre_pkg::*; (
  input  wire           clk,
  input  wire           rst,
  mre_in_if.sink        samples,
  input  mre_q_status_t q_status,
  output logic          push,
  output mre_word_t     push_word
);

  localparam logic signed [CSUM_W:0] BOUND_POS = (CSUM_W + 1)'(CSUM_BOUND);
  localparam logic signed [CSUM_W:0] BOUND_NEG = -BOUND_POS;

  sample_t                  mixture_hold;
  logic signed [CSUM_W-1:0] component_sum;

  logic                     accept;
  logic signed [CSUM_W:0]   sum_wide;
  logic signed [CSUM_W:0]   sum_clamped;
  sample_t                  mix_new;
  logic signed [CSUM_W-1:0] csum_new;
  logic signed [CSUM_W:0]   err;
  logic [CSUM_W:0]          err_mag;

  assign samples.ready = !q_status.full;
  assign accept        = samples.valid && samples.ready;

  always_comb begin
    sum_wide = {component_sum[CSUM_W-1], component_sum}
             + {{(CSUM_W + 1 - SAMPLE_W){samples.sample_value[SAMPLE_W-1]}},
                samples.sample_value};
    if (sum_wide > BOUND_POS) begin
      sum_clamped = BOUND_POS;
    end else if (sum_wide < BOUND_NEG) begin
      sum_clamped = BOUND_NEG;
    end else begin
      sum_clamped = sum_wide;
    end
    mix_new  = samples.is_component ? mixture_hold : samples.sample_value;
    csum_new = samples.is_component ? sum_clamped[CSUM_W-1:0] : component_sum;
    err      = {{(CSUM_W + 1 - SAMPLE_W){mix_new[SAMPLE_W-1]}}, mix_new}
             - {csum_new[CSUM_W-1], csum_new};
    err_mag  = err[CSUM_W] ? -err : err;
  end

  assign push              = accept && (samples.position_last || samples.signal_last);
  assign push_word.close   = samples.position_last;
  assign push_word.last    = samples.signal_last;
  assign push_word.abs_err = err_mag[ERR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mixture_hold  <= '0;
      component_sum <= '0;
    end else if (accept) begin
      if (samples.position_last || samples.signal_last) begin
        mixture_hold  <= '0;
        component_sum <= '0;
      end else begin
        mixture_hold  <= mix_new;
        component_sum <= csum_new;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mre_queue.sv
// ----------------------------------------------------------------------------
// mre_queue
// Short register queue of position words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_queue import mre_pkg::*; (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  mre_word_t     push_word,
  input  wire           pop,
  output mre_word_t     head,
  output mre_q_status_t status
);

  mre_word_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign head         = entries[rd_ptr];
  assign status.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mre_back.sv
// ----------------------------------------------------------------------------
// mre_back
// Squares and accumulates position errors; at signal end runs a bit-serial
// divide and square root if a position was counted and shows the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_back import mre_pkg::*; (
  input  wire           clk,
  input  wire           rst,
  input  mre_word_t     head,
  input  mre_q_status_t q_status,
  output logic          pop,
  mre_out_if.source     results
);

  back_state_t        state;
  back_state_t        state_next;

  // square stage
  logic               s1_valid;
  logic               s1_close;
  logic               s1_last;
  logic [ERR_W-1:0]   s1_abs;
  logic [SQ_W-1:0]    s1_sq;

  // accumulators
  logic [ERR_W-1:0]   peak;
  logic [SUM_W-1:0]   sq_sum;
  logic [COUNT_W-1:0] count;
  logic               ovf;

  // divide / root
  logic [NUM_W-1:0]   num;
  logic [COUNT_W-1:0] rem;
  logic [QUO_W-1:0]   quo;
  logic               quo_ovf;
  logic [QUO_W-1:0]   res;
  logic [QUO_W-1:0]   one;
  logic [STEP_W-1:0]  step;

  logic               s1_take;
  logic               prep;
  logic               div_step;
  logic               sqrt_step;
  logic               finish;

  logic [SUM_W:0]     sum_wide;
  logic [COUNT_W:0]   rem_sh;
  logic               rem_ge;
  logic [QUO_W-1:0]   root_t;
  logic [63:0]        lim64;
  logic [RMS_W-1:0]   lim;
  logic [RMS_W-1:0]   rms;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_ACCUM: begin
        if (s1_valid && s1_last) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = (count == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (step == STEP_W'(SQRT_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!results.valid || results.ready) begin
          state_next = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  // controls
  always_comb begin
    s1_take   = 1'b0;
    prep      = 1'b0;
    div_step  = 1'b0;
    sqrt_step = 1'b0;
    finish    = 1'b0;
    case (state)
      ST_ACCUM: s1_take   = s1_valid;
      ST_PREP:  prep      = 1'b1;
      ST_DIV:   div_step  = 1'b1;
      ST_SQRT:  sqrt_step = 1'b1;
      ST_DONE:  finish    = !results.valid || results.ready;
      default:  s1_take   = 1'b0;
    endcase
  end

  assign pop = !q_status.empty && (!s1_valid || s1_take);

  always_comb begin
    sum_wide = {1'b0, sq_sum} + (SUM_W + 1)'(s1_sq);
    rem_sh   = {rem, num[NUM_W-1]};
    rem_ge   = (rem_sh >= {1'b0, count});
    root_t   = res + one;
    lim64    = 64'(peak) << FRAC_BITS;
    lim      = (lim64 > 64'(RMS_MAX)) ? RMS_MAX : lim64[RMS_W-1:0];
    if (count == '0) begin
      rms = '0;
    end else if (quo_ovf || (64'(res) >= 64'(lim))) begin
      rms = lim;
    end else begin
      rms = res[RMS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ACCUM;
      s1_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_close <= head.close;
      s1_last  <= head.last;
      s1_abs   <= head.abs_err;
      s1_sq    <= SQ_W'(head.abs_err) * SQ_W'(head.abs_err);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak   <= '0;
      sq_sum <= '0;
      count  <= '0;
      ovf    <= 1'b0;
    end else if (finish) begin
      peak   <= '0;
      sq_sum <= '0;
      count  <= '0;
      ovf    <= 1'b0;
    end else if (s1_take && s1_close) begin
      if (s1_abs > peak) begin
        peak <= s1_abs;
      end
      if (sum_wide[SUM_W]) begin
        sq_sum <= '1;
        ovf    <= 1'b1;
      end else begin
        sq_sum <= sum_wide[SUM_W-1:0];
      end
      if (count == '1) begin
        ovf <= 1'b1;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prep) begin
      num     <= {sq_sum, {(2 * FRAC_BITS){1'b0}}};
      rem     <= '0;
      quo     <= '0;
      quo_ovf <= 1'b0;
      res     <= '0;
      one     <= ONE_INIT;
      step    <= '0;
    end else if (div_step) begin
      num     <= num << 1;
      rem     <= rem_ge ? COUNT_W'(rem_sh - {1'b0, count}) : rem_sh[COUNT_W-1:0];
      quo     <= {quo[QUO_W-2:0], rem_ge};
      quo_ovf <= quo_ovf | quo[QUO_W-1];
      step    <= (step == STEP_W'(DIV_STEPS - 1)) ? '0 : step + 1'b1;
    end else if (sqrt_step) begin
      if (quo >= root_t) begin
        quo <= quo - root_t;
        res <= (res >> 1) + one;
      end else begin
        res <= res >> 1;
      end
      one  <= one >> 2;
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (finish) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      results.peak_abs_error <= peak;
      results.rms_error_q8   <= rms;
      results.positions_seen <= count;
      results.sum_saturated  <= ovf;
    end
  end

`ifndef SYNTHESIS
  a_div_holds_acc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_SQRT) |=> $stable(sq_sum) && $stable(count))
    else $error("accumulators moved during divide or root");

  a_empty_is_clear: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (sq_sum == '0) && (peak == '0))
    else $error("error accumulated without a counted position");

  a_end_starts_div: assert property (@(posedge clk) disable iff (rst)
    (s1_take && s1_last) |=> (state == ST_PREP))
    else $error("signal end did not start the result");

  a_rms_bounded: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (64'(results.rms_error_q8) <= (64'(results.peak_abs_error) << FRAC_BITS)))
    else $error("rms above peak bound");
`endif

endmodule

`default_nettype wire

### hw/rtl/mix_reconstruction_error_meter.sv
// ----------------------------------------------------------------------------
// mix_reconstruction_error_meter
// Peak and RMS error between a mixture and the sum of its components.
// ----------------------------------------------------------------------------
// samples: one PCM16 word per item; per position the mixture word, then its
//   component words, position_last on the final one, signal_last on the final
//   word of the signal. One word is taken per cycle while the queue has room.
// results: one word per signal: peak error, RMS error (8 fraction bits),
//   positions counted and a saturation flag.
// Result path: the signal's last word passes the queue and the square stage
//   register to the accumulators, then the back end runs an 80-step restoring
//   divide and a 31-step square root, one bit per cycle; both are skipped
//   when no position was counted.
// Throughput: one word per cycle while the back end accumulates. During the
//   divide and root the front end stalls once the 4-word queue is full.
// Reset clears all accumulators, the queue and the result valid flag.
// A stalled receiver holds the result word; the back end waits in its final
//   state and the front end carries on until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module mix_reconstruction_error_meter import mre_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  mre_in_if.sink    samples,
  mre_out_if.source results
);

  logic          push;
  mre_word_t     push_word;
  logic          pop;
  mre_word_t     head;
  mre_q_status_t q_status;

  mre_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .q_status  (q_status),
    .push      (push),
    .push_word (push_word)
  );

  mre_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  mre_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .results  (results)
  );

endmodule

`default_nettype wire

### test/mix_reconstruction_error_meter_tb.sv
// ----------------------------------------------------------------------------
// mix_reconstruction_error_meter_tb
// Drives sample words through the error meter and checks every result word
// against a cycle-free model of the peak, RMS, count and saturation outputs.
// Directed checks cover empty signals, extreme samples, odd position shapes,
// component sum clipping and one long receiver hold-off that backs the meter
// up; random signals then run under four idling mixes.
// ----------------------------------------------------------------------------
module mix_reconstruction_error_meter_tb;
  import mre_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit MIX  = 1'b0;
  localparam bit COMP = 1'b1;

  localparam int HOLD_CYCLES  = 600;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    sample_t value;
    bit      comp;
    bit      pos_last;
    bit      sig_last;
  } sample_word_t;

  typedef struct {
    logic [ERR_W-1:0]   peak;
    logic [RMS_W-1:0]   rms;
    logic [COUNT_W-1:0] count;
    logic               sat;
  } reading_t;

  typedef enum {PLAIN, NO_MIXTURE, TWO_MIXTURES, MIXTURE_LAST} pos_shape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mre_in_if  sample_bus ();
  mre_out_if result_bus ();

  mix_reconstruction_error_meter dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_bus),
    .results (result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // meter model state
  sample_t            mix_hold;
  int                 comp_sum;
  logic [ERR_W-1:0]   peak_err;
  logic [SUM_W-1:0]   sq_sum;
  logic [COUNT_W-1:0] pos_count;
  bit                 sat_flag;

  reading_t expected_readings[$];

  int errors;
  int src_idle_pct;
  int snk_stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int quiet_cycles;

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // floor(sqrt(sum * 4^F / count)), limited by peak * 2^F and the field width
  function automatic logic [RMS_W-1:0] rms_q8_of(logic [SUM_W-1:0] s,
                                                 logic [COUNT_W-1:0] n,
                                                 logic [ERR_W-1:0] pk);
    logic [63:0]      lim;
    logic [NUM_W-1:0] quo;
    logic [63:0]      root;
    logic [63:0]      trial;
    lim = 64'(pk) << FRAC_BITS;
    if (lim > 64'(RMS_MAX)) lim = 64'(RMS_MAX);
    if (n == '0) return '0;
    quo = (NUM_W'(s) << (2 * FRAC_BITS)) / NUM_W'(n);
    if (quo[NUM_W-1:62] != '0) return RMS_W'(lim);
    root = '0;
    for (int i = 30; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= quo[63:0]) root = trial;
    end
    return RMS_W'((root < lim) ? root : lim);
  endfunction

  function automatic void close_position();
    int               err;
    logic [ERR_W-1:0] mag;
    logic [SUM_W-1:0] sq;
    err = int'(mix_hold) - comp_sum;
    mag = ERR_W'((err < 0) ? -err : err);
    sq  = SUM_W'(mag) * SUM_W'(mag);
    if (mag > peak_err) peak_err = mag;
    if (sq_sum > ~sq) begin
      sq_sum   = '1;
      sat_flag = 1'b1;
    end else begin
      sq_sum = sq_sum + sq;
    end
    if (pos_count == '1) sat_flag = 1'b1;
    else pos_count = pos_count + 1'b1;
    mix_hold = '0;
    comp_sum = 0;
  endfunction

  function automatic void meter_take(sample_word_t w);
    reading_t r;
    if (w.comp == MIX) begin
      mix_hold = w.value;
    end else begin
      comp_sum += int'(w.value);
      if (comp_sum > CSUM_BOUND) comp_sum = CSUM_BOUND;
      if (comp_sum < -CSUM_BOUND) comp_sum = -CSUM_BOUND;
    end
    if (w.pos_last) close_position();
    if (w.sig_last) begin
      r.peak  = peak_err;
      r.rms   = rms_q8_of(sq_sum, pos_count, peak_err);
      r.count = pos_count;
      r.sat   = sat_flag;
      expected_readings.insert(expected_readings.size(), r);
      mix_hold  = '0;
      comp_sum  = 0;
      peak_err  = '0;
      sq_sum    = '0;
      pos_count = '0;
      sat_flag  = 1'b0;
    end
  endfunction

  task automatic send_word(sample_t value, bit comp, bit pos_last, bit sig_last);
    sample_word_t w;
    w = '{value, comp, pos_last, sig_last};
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(negedge clk);
    end
    sample_bus.valid         <= 1'b1;
    sample_bus.sample_value  <= value;
    sample_bus.is_component  <= comp;
    sample_bus.position_last <= pos_last;
    sample_bus.signal_last   <= sig_last;
    do @(posedge clk); while (!sample_bus.ready);
    meter_take(w);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 3))
      0: return sample_t'($urandom);
      1: case ($urandom_range(0, 3))
           0: return -16'sd32768;
           1: return 16'sd32767;
           2: return 16'sd0;
           default: return -16'sd1;
         endcase
      2: return sample_t'(int'($urandom_range(0, 200)) - 100);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // one position, position_last on its final word
  function automatic void add_position(ref sample_word_t seq[$], input bit go_long);
    sample_t    comps[$];
    sample_t    mix;
    sample_t    rail;
    sample_t    s;
    pos_shape_t shape;
    int         k;
    int         sum;
    int         near;
    k = $urandom_range(0, 5);
    shape = (k > 3) ? PLAIN : pos_shape_t'(k);
    if (go_long) begin
      rail = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
      repeat ($urandom_range(66, 72)) comps.insert(comps.size(), rail);
      mix = (rail < 0) ? 16'sd32767 : -16'sd32768;
    end else begin
      sum = 0;
      repeat ($urandom_range((shape == NO_MIXTURE) ? 1 : 0, 4)) begin
        s = pick_sample();
        comps.insert(comps.size(), s);
        sum += int'(s);
      end
      // a good separation: mixture close to the component sum
      if ($urandom_range(0, 1)) begin
        near = sum + int'($urandom_range(0, 64)) - 32;
        if (near > 32767) near = 32767;
        if (near < -32768) near = -32768;
        mix = sample_t'(near);
      end else begin
        mix = pick_sample();
      end
    end
    if (shape == TWO_MIXTURES) seq.insert(seq.size(), '{pick_sample(), MIX, 1'b0, 1'b0});
    if (shape != NO_MIXTURE && shape != MIXTURE_LAST)
      seq.insert(seq.size(), '{mix, MIX, 1'b0, 1'b0});
    foreach (comps[i]) seq.insert(seq.size(), '{comps[i], COMP, 1'b0, 1'b0});
    if (shape == MIXTURE_LAST) seq.insert(seq.size(), '{mix, MIX, 1'b0, 1'b0});
    seq[seq.size()-1].pos_last = 1'b1;
  endfunction

  function automatic void build_signal(ref sample_word_t seq[$]);
    int n_pos;
    n_pos = $urandom_range(0, 4);
    for (int p = 0; p < n_pos; p++) add_position(seq, $urandom_range(0, 39) == 0);
    // trailing open position, never counted
    if (n_pos == 0 || $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3))
        seq.insert(seq.size(), '{pick_sample(), 1'($urandom_range(0, 1)), 1'b0, 1'b0});
    seq[seq.size()-1].sig_last = 1'b1;
  endfunction

  task automatic test_zero_positions();
    send_word(16'sd1234, MIX, 1'b0, 1'b1);
    send_word(-16'sd5, COMP, 1'b0, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_word(16'sd32767, MIX, 1'b0, 1'b0);
    send_word(-16'sd32768, COMP, 1'b1, 1'b0);
    send_word(-16'sd32768, MIX, 1'b1, 1'b0);
    send_word(16'sd32767, COMP, 1'b1, 1'b0);
    send_word(-16'sd1, MIX, 1'b0, 1'b0);
    send_word(-16'sd1, COMP, 1'b1, 1'b1);
    send_word(16'sd0, MIX, 1'b0, 1'b0);
    send_word(16'sd0, COMP, 1'b1, 1'b1);
  endtask

  task automatic test_position_shapes();
    // second mixture word replaces the first
    send_word(16'sd9000, MIX, 1'b0, 1'b0);
    send_word(16'sd300, MIX, 1'b0, 1'b0);
    send_word(16'sd100, COMP, 1'b0, 1'b0);
    send_word(16'sd150, COMP, 1'b1, 1'b0);
    // components only: mixture taken as zero
    send_word(-16'sd700, COMP, 1'b0, 1'b0);
    send_word(16'sd20, COMP, 1'b1, 1'b0);
    // signal ends with a position still open
    send_word(16'sd4000, MIX, 1'b0, 1'b0);
    send_word(-16'sd4000, COMP, 1'b0, 1'b1);
  endtask

  task automatic test_component_clipping();
    send_word(-16'sd32768, MIX, 1'b0, 1'b0);
    repeat (70) send_word(16'sd32767, COMP, 1'b0, 1'b0);
    send_word(16'sd32767, COMP, 1'b1, 1'b0);
    send_word(16'sd32767, MIX, 1'b0, 1'b0);
    repeat (64) send_word(-16'sd32768, COMP, 1'b0, 1'b0);
    send_word(-16'sd32768, COMP, 1'b1, 1'b0);
    send_word(16'sd32767, MIX, 1'b0, 1'b0);
    repeat (69) send_word(-16'sd32768, COMP, 1'b0, 1'b0);
    send_word(-16'sd32768, COMP, 1'b1, 1'b1);
  endtask

  // receiver holds off while short signals keep coming: the queue fills up
  task automatic test_backpressure_fill();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req++;
    repeat (8) begin
      send_word(pick_sample(), MIX, 1'b0, 1'b0);
      send_word(pick_sample(), COMP, 1'b1, 1'b0);
      send_word(pick_sample(), COMP, 1'b1, 1'b1);
    end
  endtask

  task automatic test_random_signals(int src_pct, int snk_pct, int n_words);
    sample_word_t seq[$];
    int           sent;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    sent = 0;
    while (sent < n_words) begin
      seq.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          seq.insert(seq.size(), '{sample_t'($urandom), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0});
      end else begin
        build_signal(seq);
      end
      foreach (seq[i]) send_word(seq[i].value, seq[i].comp, seq[i].pos_last, seq[i].sig_last);
      sent += seq.size();
    end
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected result word: peak %0d rms %0d count %0d",
                                  result_bus.peak_abs_error, result_bus.rms_error_q8,
                                  result_bus.positions_seen));
      end else begin
        want = expected_readings.pop_front();
        if (result_bus.peak_abs_error !== want.peak)
          report_mismatch($sformatf("peak_abs_error %0d, expected %0d",
                                    result_bus.peak_abs_error, want.peak));
        if (result_bus.rms_error_q8 !== want.rms)
          report_mismatch($sformatf("rms_error_q8 %0d, expected %0d",
                                    result_bus.rms_error_q8, want.rms));
        if (result_bus.positions_seen !== want.count)
          report_mismatch($sformatf("positions_seen %0d, expected %0d",
                                    result_bus.positions_seen, want.count));
        if (result_bus.sum_saturated !== want.sat)
          report_mismatch($sformatf("sum_saturated %0b, expected %0b",
                                    result_bus.sum_saturated, want.sat));
      end
    end
  end

  // watchdog: too long with no word moving on either side
  always @(posedge clk) begin
    if (rst || (sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("mix_reconstruction_error_meter regression: fail");
      $finish;
    end
  end

  initial begin
    mix_hold      = '0;
    comp_sum      = 0;
    peak_err      = '0;
    sq_sum        = '0;
    pos_count     = '0;
    sat_flag      = 1'b0;
    errors        = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    sample_bus.valid         = 1'b0;
    sample_bus.sample_value  = '0;
    sample_bus.is_component  = 1'b0;
    sample_bus.position_last = 1'b0;
    sample_bus.signal_last   = 1'b0;
    result_bus.ready         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_zero_positions();
    test_field_extremes();
    test_position_shapes();
    test_component_clipping();
    test_backpressure_fill();
    test_random_signals(0, 0, 40);
    test_random_signals(63, 0, 40);
    test_random_signals(0, 63, 40);
    test_random_signals(36, 36, 40);

    @(negedge clk);
    sample_bus.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("mix_reconstruction_error_meter regression: pass");
    else
      $display("mix_reconstruction_error_meter regression: fail");
    $finish;
  end

endmodule

### files.f
hw/rtl/mre_pkg.sv
hw/rtl/mre_if.sv
hw/rtl/mre_front.sv
hw/rtl/mre_queue.sv
hw/rtl/mre_back.sv
hw/rtl/mix_reconstruction_error_meter.sv
test/mix_reconstruction_error_meter_tb.sv
